@@ hw/rtl/pbq_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pbq_pkg: shared types and constants of the per-dimension bin quantizer
// request layouts, action codes and default table sizes
// ----------------------------------------------------------------------------
package pbq_pkg;

  localparam int unsigned PBQ_DIMS      = 16;
  localparam int unsigned PBQ_MAX_CELLS = 256;
  localparam int unsigned PBQ_VAL_W     = 32;

  typedef enum logic [1:0] {
    ACT_WR_BOUND = 2'd0,
    ACT_WR_COUNT = 2'd1,
    ACT_QUANT    = 2'd2
  } pbq_action_e;

  typedef struct packed {
    logic [1:0]                  action;
    logic [3:0]                  dimension;
    logic [8:0]                  boundary_slot;
    logic signed [PBQ_VAL_W-1:0] sample_value;
    logic [8:0]                  cells_in_dim;
  } pbq_in_req_t;

  typedef struct packed {
    logic [7:0] cell_index;
    logic       below_range;
    logic       above_range;
  } pbq_out_req_t;

endpackage

@@ hw/rtl/pbq_bnd_ram.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pbq_bnd_ram: boundary store
// single-port memory, one write or one registered read per cycle
// ----------------------------------------------------------------------------
module pbq_bnd_ram #(
  parameter int unsigned DEPTH  = 4112,
  parameter int unsigned ADDR_W = 13
) (
  input  logic                                 clk_i,
  input  logic                                 we_i,
  input  logic [ADDR_W-1:0]                    addr_i,
  input  logic signed [pbq_pkg::PBQ_VAL_W-1:0] wdata_i,
  output logic signed [pbq_pkg::PBQ_VAL_W-1:0] rdata_o
);
  import pbq_pkg::*;

  logic signed [PBQ_VAL_W-1:0] mem_q [DEPTH];
  logic signed [PBQ_VAL_W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_q <= mem_q[addr_i];
  end

  assign rdata_o = rdata_q;

endmodule

@@ hw/rtl/pbq_ctrl.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pbq_ctrl: quantizer sequencer
// holds the cell count table, drives the boundary store and walks the cells
// with one shared signed compare
// ----------------------------------------------------------------------------
module pbq_ctrl #(
  parameter int unsigned DIMS      = 16,
  parameter int unsigned MAX_CELLS = 256,
  parameter int unsigned ADDR_W    = 13
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 in_valid_i,
  output logic                                 in_ready_o,
  input  pbq_pkg::pbq_in_req_t                 in_req_i,
  output logic                                 res_valid_o,
  input  logic                                 res_ready_i,
  output pbq_pkg::pbq_out_req_t                res_o,
  output logic                                 ram_we_o,
  output logic [ADDR_W-1:0]                    ram_addr_o,
  output logic signed [pbq_pkg::PBQ_VAL_W-1:0] ram_wdata_o,
  input  logic signed [pbq_pkg::PBQ_VAL_W-1:0] ram_rdata_i
);
  import pbq_pkg::*;

  localparam int unsigned Slots = MAX_CELLS + 1;
  localparam int unsigned SlotW = $clog2(MAX_CELLS + 1);
  localparam int unsigned DimW  = (DIMS > 1) ? $clog2(DIMS) : 1;

  typedef enum logic [2:0] {
    S_IDLE,
    S_B0,
    S_TOP,
    S_SCAN,
    S_RESP
  } state_e;

  state_e                      state_q, state_d;
  logic signed [PBQ_VAL_W-1:0] value_q, value_d;
  logic [ADDR_W-1:0]           base_q, base_d;
  logic [SlotW-1:0]            cnt_q, cnt_d;
  logic [SlotW-1:0]            c_q, c_d;
  logic                        ge_q, ge_d;
  pbq_out_req_t                res_q, res_d;

  logic [SlotW-1:0] cnt_mem_q [DIMS];
  logic [SlotW-1:0] cnt_rd_q;

  logic              in_acc;
  logic              dim_ok;
  logic              slot_ok;
  logic [DimW-1:0]   dim_idx;
  logic [ADDR_W-1:0] in_base;
  logic [SlotW-1:0]  cnt_clamp;
  logic              cnt_we;
  logic              lt;

  assign in_ready_o = (state_q == S_IDLE);
  assign in_acc     = in_valid_i && in_ready_o;
  assign dim_ok     = 32'(in_req_i.dimension) < 32'(DIMS);
  assign slot_ok    = 32'(in_req_i.boundary_slot) <= 32'(MAX_CELLS);
  assign dim_idx    = DimW'(in_req_i.dimension);
  assign in_base    = ADDR_W'(dim_idx) * ADDR_W'(Slots);

  // count of zero becomes one, counts above the table size are clipped
  always_comb begin
    if (in_req_i.cells_in_dim == '0) begin
      cnt_clamp = SlotW'(1);
    end else if (32'(in_req_i.cells_in_dim) > 32'(MAX_CELLS)) begin
      cnt_clamp = SlotW'(MAX_CELLS);
    end else begin
      cnt_clamp = SlotW'(in_req_i.cells_in_dim);
    end
  end

  assign cnt_we = in_acc && dim_ok && (in_req_i.action == ACT_WR_COUNT);

  always_ff @(posedge clk_i) begin
    if (cnt_we) begin
      cnt_mem_q[dim_idx] <= cnt_clamp;
    end
    cnt_rd_q <= cnt_mem_q[dim_idx];
  end

  // shared compare: value against the boundary read last cycle
  assign lt = value_q < ram_rdata_i;

  assign ram_we_o    = in_acc && dim_ok && slot_ok && (in_req_i.action == ACT_WR_BOUND);
  assign ram_wdata_o = in_req_i.sample_value;

  always_comb begin
    case (state_q)
      S_IDLE: begin
        if (in_req_i.action == ACT_WR_BOUND) begin
          ram_addr_o = in_base + ADDR_W'(in_req_i.boundary_slot);
        end else begin
          ram_addr_o = in_base;
        end
      end
      S_B0:    ram_addr_o = base_q + ADDR_W'(cnt_rd_q);
      S_TOP:   ram_addr_o = base_q + ADDR_W'(1);
      S_SCAN:  ram_addr_o = base_q + ADDR_W'(c_q) + ADDR_W'(2);
      default: ram_addr_o = base_q;
    endcase
  end

  always_comb begin
    state_d = state_q;
    value_d = value_q;
    base_d  = base_q;
    cnt_d   = cnt_q;
    c_d     = c_q;
    ge_d    = ge_q;
    res_d   = res_q;
    case (state_q)
      S_IDLE: begin
        if (in_acc && dim_ok && (in_req_i.action == ACT_QUANT)) begin
          value_d = in_req_i.sample_value;
          base_d  = in_base;
          state_d = S_B0;
        end
      end
      S_B0: begin
        cnt_d = cnt_rd_q;
        if (lt) begin
          res_d   = '{cell_index: 8'd0, below_range: 1'b1, above_range: 1'b0};
          state_d = S_RESP;
        end else begin
          state_d = S_TOP;
        end
      end
      S_TOP: begin
        if (!lt) begin
          res_d.cell_index  = (cnt_q == '0) ? 8'd0 : 8'(SlotW'(cnt_q - 1'b1));
          res_d.below_range = 1'b0;
          res_d.above_range = 1'b1;
          state_d           = S_RESP;
        end else begin
          c_d     = '0;
          ge_d    = 1'b1;
          state_d = S_SCAN;
        end
      end
      S_SCAN: begin
        if (ge_q && lt) begin
          res_d   = '{cell_index: 8'(c_q), below_range: 1'b0, above_range: 1'b0};
          state_d = S_RESP;
        end else if (c_q == SlotW'(cnt_q - 1'b1)) begin
          // disordered boundaries with no matching cell
          res_d   = '{cell_index: 8'd0, below_range: 1'b0, above_range: 1'b0};
          state_d = S_RESP;
        end else begin
          ge_d = !lt;
          c_d  = SlotW'(c_q + 1'b1);
        end
      end
      S_RESP: begin
        if (res_ready_i) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
      value_q <= value_d;
      base_q  <= base_d;
      cnt_q   <= cnt_d;
      c_q     <= c_d;
      ge_q    <= ge_d;
      res_q   <= res_d;
    end
  end

  assign res_valid_o = (state_q == S_RESP);
  assign res_o       = res_q;

endmodule

@@ hw/rtl/per_dimension_bin_quantizer_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// per_dimension_bin_quantizer_top: per-dimension nonuniform scalar quantizer
// boundary and cell count tables per dimension, Q16.16 coefficient binning
// ----------------------------------------------------------------------------
// Each request either writes one boundary, writes one dimension's cell count
// or quantizes one Q16.16 coefficient; only a quantize of a dimension below
// DIMS returns a response. The block stays ready after a write. A quantize
// runs through one single-port boundary memory and one signed comparator,
// one boundary per cycle: it checks boundary 0 (below range), then the last
// boundary (above range), then walks the cells upward from cell 0; with no
// matching cell it answers cell 0 with no flag. The linear walk returns the
// lowest matching cell even for disordered boundaries. The tables are not
// cleared at reset, so no clearing pass is needed; quantizing against
// entries never written gives an arbitrary cell. A finished response sits
// in an output register, so the next request is taken while it waits.
module per_dimension_bin_quantizer_top #(
  parameter int unsigned DIMS      = pbq_pkg::PBQ_DIMS,
  parameter int unsigned MAX_CELLS = pbq_pkg::PBQ_MAX_CELLS
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  pbq_pkg::pbq_in_req_t  in_req_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output pbq_pkg::pbq_out_req_t out_req_o
);
  import pbq_pkg::*;

  // flat boundary store: dimension d owns entries d*(MAX_CELLS+1) onward
  localparam int unsigned Depth = DIMS * (MAX_CELLS + 1);
  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1;

  logic                        res_valid;
  logic                        res_ready;
  pbq_out_req_t                res;
  logic                        ram_we;
  logic [AddrW-1:0]            ram_addr;
  logic signed [PBQ_VAL_W-1:0] ram_wdata;
  logic signed [PBQ_VAL_W-1:0] ram_rdata;

  logic         out_valid_q, out_valid_d;
  pbq_out_req_t out_req_q, out_req_d;

  // sequencer with the count table and the shared compare
  pbq_ctrl #(
    .DIMS      (DIMS),
    .MAX_CELLS (MAX_CELLS),
    .ADDR_W    (AddrW)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_req_i    (in_req_i),
    .res_valid_o (res_valid),
    .res_ready_i (res_ready),
    .res_o       (res),
    .ram_we_o    (ram_we),
    .ram_addr_o  (ram_addr),
    .ram_wdata_o (ram_wdata),
    .ram_rdata_i (ram_rdata)
  );

  pbq_bnd_ram #(
    .DEPTH  (Depth),
    .ADDR_W (AddrW)
  ) u_bnd_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .addr_i  (ram_addr),
    .wdata_i (ram_wdata),
    .rdata_o (ram_rdata)
  );

  // output register: loads when empty or being drained this cycle
  assign res_ready = !out_valid_q || out_ready_i;

  always_comb begin
    out_valid_d = out_valid_q;
    out_req_d   = out_req_q;
    if (res_ready) begin
      out_valid_d = res_valid;
      if (res_valid) begin
        out_req_d = res;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
      out_req_q   <= out_req_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_req_o   = out_req_q;

endmodule

@@ hw/rtl/pbq_chk.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pbq_chk: port checker for the bin quantizer
// watches the top level ports and flags response and flow slips
// ----------------------------------------------------------------------------
module pbq_chk #(
  parameter int unsigned DIMS = pbq_pkg::PBQ_DIMS
) (
  input logic                  clk_i,
  input logic                  rst_ni,
  input logic                  in_valid_i,
  input logic                  in_ready_o,
  input pbq_pkg::pbq_in_req_t  in_req_i,
  input logic                  out_valid_o,
  input logic                  out_ready_i,
  input pbq_pkg::pbq_out_req_t out_req_o
);
  import pbq_pkg::*;

  logic in_acc;
  logic quant_ok;

  assign in_acc   = in_valid_i && in_ready_o;
  assign quant_ok = (in_req_i.action == ACT_QUANT) && (32'(in_req_i.dimension) < 32'(DIMS));

  // a value cannot be both below and above the range
  a_flags_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !(out_req_o.below_range && out_req_o.above_range))
    else $error("below and above flags both set");

  // below range always maps to the first cell
  a_below_cell0: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_req_o.below_range |-> out_req_o.cell_index == 8'd0)
    else $error("below range with nonzero cell");

  // a quantize keeps the block busy for the following cycle
  a_quant_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && quant_ok |=> !in_ready_o)
    else $error("ready right after a quantize request");

  // writes and ignored requests leave the block ready
  a_write_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && !quant_ok |=> in_ready_o)
    else $error("not ready after a write request");

  // stalled response holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_req_o))
    else $error("stalled response dropped or changed");

endmodule

bind per_dimension_bin_quantizer_top pbq_chk #(.DIMS(DIMS)) u_pbq_chk (.*);

@@ test/testbench.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: self-checking bench for per_dimension_bin_quantizer_top
// programs per-dimension boundary tables and cell counts, quantizes values on,
// next to and between boundaries, and checks every response against a
// behavioral quantizer kept inside the bench, under random idling on both sides
// ----------------------------------------------------------------------------
module testbench;
  import pbq_pkg::*;

  localparam int unsigned SLOTS        = PBQ_MAX_CELLS + 1;
  localparam int unsigned RANDOM_ITEMS = 700;
  // margin for the longest quantize walk plus both sides' idling
  localparam int unsigned TAIL_CYCLES  = 300;
  localparam int unsigned QUIET_LIMIT  = 4000;
  // action code the block leaves unused
  localparam logic [1:0]  ACT_UNUSED   = 2'd3;

  logic         clk_i;
  logic         rst_ni      = 1'b0;
  logic         in_valid_i  = 1'b0;
  logic         in_ready_o;
  pbq_in_req_t  in_req_i    = '0;
  logic         out_valid_o;
  logic         out_ready_i = 1'b0;
  pbq_out_req_t out_req_o;

  per_dimension_bin_quantizer_top dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_req_i    (in_req_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_req_o   (out_req_o)
  );

  // requests waiting for the driver, responses waiting for the monitor
  pbq_in_req_t  pending_reqs[$];
  pbq_out_req_t expected_cells[$];
  int unsigned  fail_count = 0;

  // quantizer state as seen by accepted requests
  logic signed [31:0] bound_mem [PBQ_DIMS][SLOTS];
  int unsigned        cell_total [PBQ_DIMS];

  // stimulus-side shadow: which entries are written, so that no quantize
  // ever reads a boundary or count that was never written
  logic signed [31:0] plan_bound   [PBQ_DIMS][SLOTS];
  bit                 plan_written [PBQ_DIMS][SLOTS];
  int unsigned        plan_cells   [PBQ_DIMS];
  int unsigned        planned_items = 0;

  // idling state of both sides
  int unsigned feed_gap    = 0;
  bit          feed_calm   = 1'b0;
  int unsigned drain_stall = 0;
  bit          drain_calm  = 1'b0;
  int unsigned quiet_cycles = 0;

  // --------------------------------------------------------------------------
  // behavioral quantizer
  // --------------------------------------------------------------------------

  // lowest cell whose half-open interval holds the value, flags outside
  function automatic pbq_out_req_t locate_cell(int unsigned d, logic signed [31:0] v);
    pbq_out_req_t res;
    int unsigned  n;
    res = '0;
    n   = cell_total[d];
    if (v < bound_mem[d][0]) begin
      res.below_range = 1'b1;
    end else if (v >= bound_mem[d][n]) begin
      res.above_range = 1'b1;
      res.cell_index  = 8'(n - 1);
    end else begin
      for (int c = 0; c < n; c++) begin
        if (v >= bound_mem[d][c] && v < bound_mem[d][c+1]) begin
          res.cell_index = 8'(c);
          break;
        end
      end
    end
    return res;
  endfunction

  // applies one accepted request; a quantize queues its expected response
  function automatic void absorb_request(pbq_in_req_t req);
    int unsigned        n;
    logic signed [31:0] v;
    n = req.cells_in_dim;
    v = req.sample_value;
    case (req.action)
      ACT_WR_BOUND: begin
        // slots past the table end are dropped
        if (req.boundary_slot <= PBQ_MAX_CELLS)
          bound_mem[req.dimension][req.boundary_slot] = v;
      end
      ACT_WR_COUNT: begin
        // zero counts as one cell, oversize clamps to the table size
        if (n == 0) n = 1;
        if (n > PBQ_MAX_CELLS) n = PBQ_MAX_CELLS;
        cell_total[req.dimension] = n;
      end
      ACT_QUANT: expected_cells.push_back(locate_cell(req.dimension, v));
      default: ;
    endcase
  endfunction

  // --------------------------------------------------------------------------
  // stimulus planning
  // --------------------------------------------------------------------------

  // queues one request and tracks what it leaves written
  function automatic void issue(logic [1:0] act, int unsigned dim, int unsigned slot,
                                logic signed [31:0] val, int unsigned cells);
    pbq_in_req_t req;
    int unsigned n;
    req.action        = act;
    req.dimension     = dim[3:0];
    req.boundary_slot = slot[8:0];
    req.sample_value  = val;
    req.cells_in_dim  = cells[8:0];
    pending_reqs.push_back(req);
    n = req.cells_in_dim;
    if (act == ACT_WR_BOUND && req.boundary_slot <= PBQ_MAX_CELLS) begin
      plan_bound[dim][req.boundary_slot]   = val;
      plan_written[dim][req.boundary_slot] = 1'b1;
      planned_items++;
    end else if (act == ACT_WR_COUNT) begin
      if (n == 0) n = 1;
      if (n > PBQ_MAX_CELLS) n = PBQ_MAX_CELLS;
      plan_cells[dim] = n;
      planned_items++;
    end else if (act == ACT_QUANT) begin
      planned_items++;
    end
  endfunction

  // a dimension may be quantized once its count and boundaries 0..count exist
  function automatic bit dim_ready(int unsigned d);
    if (plan_cells[d] == 0) return 1'b0;
    for (int s = 0; s <= plan_cells[d]; s++)
      if (!plan_written[d][s]) return 1'b0;
    return 1'b1;
  endfunction

  function automatic int pick_ready_dim();
    int unsigned start;
    start = $urandom_range(0, PBQ_DIMS - 1);
    for (int i = 0; i < PBQ_DIMS; i++)
      if (dim_ready((start + i) % PBQ_DIMS)) return (start + i) % PBQ_DIMS;
    return -1;
  endfunction

  // boundary step size; zero means unordered boundaries
  function automatic int unsigned pick_spread();
    case ($urandom_range(0, 4))
      0:       return 0;
      1:       return 1;
      2:       return 32'h100;
      3:       return 32'h1_0000;
      default: return 32'h100_0000;
    endcase
  endfunction

  // writes a full table: count plus boundaries 0..n, count first or last
  function automatic void program_dim(int unsigned d, int unsigned n, int unsigned spread,
                                      bit count_last, bit from_bottom);
    longint      b;
    int unsigned code;
    code = n;
    // also exercise the stored-as-one and clamp encodings
    if (n == 1 && $urandom_range(0, 1)) code = 0;
    if (n == PBQ_MAX_CELLS && $urandom_range(0, 1))
      code = $urandom_range(PBQ_MAX_CELLS + 1, 511);
    if (!count_last)
      issue(ACT_WR_COUNT, d, $urandom_range(0, 511), $urandom, code);
    if (from_bottom)
      b = -longint'(64'h8000_0000) + $urandom_range(0, 65535);
    else
      b = longint'($signed($urandom) >>> $urandom_range(0, 31));
    for (int s = 0; s <= n; s++) begin
      if (spread == 0) b = longint'($signed($urandom));
      else if (s > 0) b += $urandom_range(0, spread);
      if (b > 64'sh7FFF_FFFF) b = 64'sh7FFF_FFFF;
      issue(ACT_WR_BOUND, d, s, b[31:0], $urandom_range(0, 511));
    end
    if (count_last)
      issue(ACT_WR_COUNT, d, $urandom_range(0, 511), $urandom, code);
  endfunction

  // values on, just off and between boundaries, plus anything at all
  function automatic void quantize_near(int unsigned d);
    int unsigned        k;
    logic signed [31:0] v;
    k = $urandom_range(0, plan_cells[d]);
    case ($urandom_range(0, 4))
      0:       v = plan_bound[d][k] - 1;
      1:       v = plan_bound[d][k];
      2:       v = plan_bound[d][k] + 1;
      3:       v = plan_bound[d][k] + ($urandom >> $urandom_range(8, 31));
      default: v = $urandom;
    endcase
    issue(ACT_QUANT, d, $urandom_range(0, 511), v, $urandom_range(0, 511));
  endfunction

  // --------------------------------------------------------------------------
  // clock
  // --------------------------------------------------------------------------
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // --------------------------------------------------------------------------
  // request driver: presents queued requests, idles a drawn number of cycles
  // after each, and feeds every accepted request to the quantizer model
  // --------------------------------------------------------------------------
  always @(posedge clk_i or negedge rst_ni) begin : feed_side
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else begin
      if (in_valid_i && in_ready_o) begin
        absorb_request(in_req_i);
      end
      // payload only moves once the current request is gone
      if (!in_valid_i || in_ready_o) begin
        if (feed_gap != 0) begin
          feed_gap--;
          in_valid_i <= 1'b0;
        end else if (pending_reqs.size() != 0) begin
          in_req_i   <= pending_reqs.pop_front();
          in_valid_i <= 1'b1;
          // occasionally switch between idling and back-to-back stretches
          if ($urandom_range(0, 39) == 0) feed_calm = !feed_calm;
          feed_gap = feed_calm ? 0 : $urandom_range(0, 9);
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // response monitor: checks each response against the oldest expectation and
  // holds ready low for a drawn number of cycles after each one
  // --------------------------------------------------------------------------
  always @(posedge clk_i or negedge rst_ni) begin : drain_side
    pbq_out_req_t want;
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
    end else if (out_valid_o && out_ready_i) begin
      if (expected_cells.size() == 0) begin
        $error("unexpected response: cell_index %0d below_range %0b above_range %0b",
               out_req_o.cell_index, out_req_o.below_range, out_req_o.above_range);
        fail_count++;
      end else begin
        want = expected_cells.pop_front();
        if (out_req_o.cell_index !== want.cell_index) begin
          $error("cell_index: expected %0d, got %0d", want.cell_index, out_req_o.cell_index);
          fail_count++;
        end
        if (out_req_o.below_range !== want.below_range) begin
          $error("below_range: expected %0b, got %0b", want.below_range,
                 out_req_o.below_range);
          fail_count++;
        end
        if (out_req_o.above_range !== want.above_range) begin
          $error("above_range: expected %0b, got %0b", want.above_range,
                 out_req_o.above_range);
          fail_count++;
        end
      end
      if ($urandom_range(0, 39) == 0) drain_calm = !drain_calm;
      drain_stall = drain_calm ? 0 : $urandom_range(0, 9);
      out_ready_i <= (drain_stall == 0);
    end else if (!out_ready_i && (out_valid_o || drain_stall == 0)) begin
      // the stall counts down while a response is waiting
      if (drain_stall <= 1) out_ready_i <= 1'b1;
      if (drain_stall != 0) drain_stall--;
    end
  end

  // --------------------------------------------------------------------------
  // watchdog: too long without any handshake means the block hung
  // --------------------------------------------------------------------------
  always @(posedge clk_i) begin : watchdog
    if (!rst_ni || (in_valid_i && in_ready_o) || (out_valid_o && out_ready_i))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles == QUIET_LIMIT) begin
      $display("[per_dimension_bin_quantizer_top] ERROR");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // stimulus and end of run
  // --------------------------------------------------------------------------
  initial begin : stimulus
    int r;
    int d;
    int unsigned n;
    bit big_done;
    big_done = 1'b0;

    // single cell spanning the whole Q16.16 range
    issue(ACT_WR_COUNT, 0, 0, 0, 0);
    issue(ACT_WR_BOUND, 0, 0, 32'sh8000_0000, 0);
    issue(ACT_WR_BOUND, 0, 1, 32'sh7FFF_FFFF, 0);
    issue(ACT_QUANT, 0, 0, 32'sh8000_0000, 0);
    issue(ACT_QUANT, 0, 0, 32'sh7FFF_FFFF, 0);

    // disordered boundaries on the top dimension: lowest match wins
    issue(ACT_WR_COUNT, 15, 511, 32'hFFFF_FFFF, 3);
    issue(ACT_WR_BOUND, 15, 0, 32'sh0000_0000, 511);
    issue(ACT_WR_BOUND, 15, 1, 32'sh0002_0000, 511);
    issue(ACT_WR_BOUND, 15, 2, 32'sh0001_0000, 511);
    issue(ACT_WR_BOUND, 15, 3, 32'sh0003_0000, 511);
    issue(ACT_QUANT, 15, 0, -32'sd1, 0);
    issue(ACT_QUANT, 15, 0, 32'sh0001_8000, 0);
    issue(ACT_QUANT, 15, 0, 32'sh0002_8000, 0);
    issue(ACT_QUANT, 15, 0, 32'sh0003_0000, 0);
    // write past the table end is dropped, unused action gives nothing
    issue(ACT_WR_BOUND, 15, 300, 32'sh7FFF_0000, 0);
    issue(ACT_QUANT, 15, 0, 32'sh0000_0000, 0);
    issue(ACT_UNUSED, 15, 511, 32'hFFFF_FFFF, 511);
    // oversize count clamps, then shrink back to two cells
    issue(ACT_WR_COUNT, 15, 0, 0, 511);
    issue(ACT_WR_COUNT, 15, 0, 0, 2);
    issue(ACT_QUANT, 15, 0, 32'sh0002_0000, 0);

    // equal boundaries: an empty cell
    issue(ACT_WR_COUNT, 1, 0, 0, 1);
    issue(ACT_WR_BOUND, 1, 0, 32'sd5, 0);
    issue(ACT_WR_BOUND, 1, 1, 32'sd5, 0);
    issue(ACT_QUANT, 1, 0, 32'sd5, 0);
    issue(ACT_QUANT, 1, 0, 32'sd4, 0);

    // random part: mostly quantizes against programmed tables, with table
    // rewrites, count changes and ignored requests mixed in
    planned_items = 0;
    while (planned_items < RANDOM_ITEMS) begin
      r = $urandom_range(0, 99);
      d = pick_ready_dim();
      if (!big_done && planned_items >= RANDOM_ITEMS / 3) begin
        // one full-size table with widely spread boundaries, quantized near them
        d = $urandom_range(0, PBQ_DIMS - 1);
        program_dim(d, PBQ_MAX_CELLS, 32'h80_0000, 1'b0, 1'b1);
        repeat (24) quantize_near(d);
        big_done = 1'b1;
      end else if (d < 0 || r < 12) begin
        n = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 40) : $urandom_range(1, 8);
        program_dim($urandom_range(0, PBQ_DIMS - 1), n, pick_spread(),
                    $urandom_range(0, 1), 1'b0);
      end else if (r < 80) begin
        quantize_near(d);
      end else if (r < 88) begin
        issue(ACT_WR_BOUND, d, $urandom_range(0, plan_cells[d]), $urandom,
              $urandom_range(0, 511));
      end else if (r < 92) begin
        // shrinking keeps every needed boundary written
        issue(ACT_WR_COUNT, d, $urandom_range(0, 511), $urandom,
              $urandom_range(0, plan_cells[d]));
      end else if (r < 96) begin
        issue(ACT_UNUSED, $urandom_range(0, PBQ_DIMS - 1), $urandom_range(0, 511),
              $urandom, $urandom_range(0, 511));
      end else begin
        issue(ACT_WR_BOUND, $urandom_range(0, PBQ_DIMS - 1), $urandom_range(SLOTS, 511),
              $urandom, $urandom_range(0, 511));
      end
    end

    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;

    // drain everything, then watch a while for stray responses
    while (pending_reqs.size() != 0 || in_valid_i || expected_cells.size() != 0)
      @(posedge clk_i);
    repeat (TAIL_CYCLES) @(posedge clk_i);

    if (fail_count == 0) begin
      $display("[per_dimension_bin_quantizer_top] OK");
    end else begin
      $display("[per_dimension_bin_quantizer_top] ERROR");
    end
    $finish;
  end

endmodule
